// ===== hdl/vsa_pkg.sv =====
`default_nettype none

package vsa_pkg;

   localparam int MAX_VOICES = 16;
   localparam int VOICE_W    = $clog2(MAX_VOICES);
   localparam int COUNT_W    = $clog2(MAX_VOICES + 1);
   localparam int TIME_W     = 24;

   typedef struct packed {
      logic [TIME_W-1:0]  wait_time;
      logic               continues_prev;
      logic [VOICE_W-1:0] prev_voice;
      logic               later_used;
      logic [TIME_W-1:0]  event_duration;
   } vsa_req_type;

   typedef struct packed {
      logic [VOICE_W-1:0] voice_number;
      logic               new_voice;
      logic               overflow;
      logic [COUNT_W-1:0] voices_in_use;
   } vsa_rsp_type;

   // one slot of the voice table
   typedef struct packed {
      logic              reserved_flag;
      logic [TIME_W-1:0] remaining_time;
   } vsa_entry_type;

   typedef struct packed {
      logic               en;
      logic [VOICE_W-1:0] addr;
      vsa_entry_type      data;
   } vsa_wr_type;

   typedef struct packed {
      logic               en;
      logic [VOICE_W-1:0] addr;
   } vsa_rd_type;

   typedef enum logic [1:0] {
      VSA_IDLE,
      VSA_SCAN,
      VSA_WRITE,
      VSA_DONE
   } vsa_state_type;

endpackage

`default_nettype wire

// ===== hdl/voice_slot_allocator.sv =====
// Voice slot allocator: gives each timed event of a score a voice slot.
// Input channel req_*: one event item (wait, continuation, later-used mark,
// duration). Result channel rsp_*: one item per event with the voice number,
// fresh-slot and overflow flags, and the slot count after the event.
// Both channels are valid/ready; an item moves when valid and ready are high.
// Slot state lives in a 16-entry table memory with a registered read port.
// Each event sweeps the allocated slots one memory read a cycle, decrementing
// by the wait and looking for the lowest free unreserved slot, then writes
// the chosen slot. The sweep is longer the more slots are in use before the
// event. A new item is taken the cycle after the result is loaded, so the
// block works on one event at a time.
// The single read port of the table paces the sweep.
// The result sits in an output register: the block takes the next item while
// it waits. If the receiver stalls, a second result is held back inside until
// the register frees, and no further item is taken meanwhile.
// Reset (synchronous, active high) empties the table: no slots in use.
// Table contents need no clearing; a slot is always written when allocated.
`default_nettype none

module voice_slot_allocator (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_ready,
   input  vsa_pkg::vsa_req_type     req_payload,
   output logic                     rsp_valid,
   input  wire                      rsp_ready,
   output vsa_pkg::vsa_rsp_type     rsp_payload
);

   logic                    rsp_valid_ff, rsp_valid_in;
   vsa_pkg::vsa_rsp_type    rsp_ff, rsp_in;
   logic                    out_free;
   logic                    res_load;
   vsa_pkg::vsa_rsp_type    res_data;
   vsa_pkg::vsa_wr_type     wr;
   vsa_pkg::vsa_rd_type     rd;
   vsa_pkg::vsa_entry_type  rd_data;

   // output register is free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   vsa_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .out_free    (out_free),
      .res_load    (res_load),
      .res_data    (res_data),
      .wr          (wr),
      .rd          (rd),
      .rd_data     (rd_data)
   );

   vsa_ram u_ram (
      .clock   (clock),
      .wr      (wr),
      .rd      (rd),
      .rd_data (rd_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_load) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res_data;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

// ===== hdl/vsa_ram.sv =====
`default_nettype none

module vsa_ram (
   input  wire                      clock,
   input  vsa_pkg::vsa_wr_type      wr,
   input  vsa_pkg::vsa_rd_type      rd,
   output vsa_pkg::vsa_entry_type   rd_data
);

   vsa_pkg::vsa_entry_type mem_ff [vsa_pkg::MAX_VOICES];
   vsa_pkg::vsa_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_data_ff <= mem_ff[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/vsa_ctrl.sv =====
`default_nettype none

module vsa_ctrl (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_ready,
   input  vsa_pkg::vsa_req_type     req_payload,
   input  wire                      out_free,
   output logic                     res_load,
   output vsa_pkg::vsa_rsp_type     res_data,
   output vsa_pkg::vsa_wr_type      wr,
   output vsa_pkg::vsa_rd_type      rd,
   input  vsa_pkg::vsa_entry_type   rd_data
);

   vsa_pkg::vsa_state_type          state_ff, state_in;
   logic [vsa_pkg::COUNT_W-1:0]     slot_count_ff, slot_count_in;
   logic                            chk_valid_ff, chk_valid_in;
   vsa_pkg::vsa_req_type            req_ff, req_in;
   vsa_pkg::vsa_rsp_type            res_ff, res_in;
   logic [vsa_pkg::COUNT_W-1:0]     rd_idx_ff, rd_idx_in;
   logic [vsa_pkg::VOICE_W-1:0]     chk_idx_ff, chk_idx_in;
   logic                            found_ff, found_in;
   logic [vsa_pkg::VOICE_W-1:0]     chosen_ff, chosen_in;
   logic [vsa_pkg::TIME_W-1:0]      dec_time;

   // saturating decrement of the slot coming back from memory
   assign dec_time = (rd_data.remaining_time < req_ff.wait_time) ? '0
                   : rd_data.remaining_time - req_ff.wait_time;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= vsa_pkg::VSA_IDLE;
         slot_count_ff <= '0;
         chk_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         slot_count_ff <= slot_count_in;
         chk_valid_ff  <= chk_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      res_ff     <= res_in;
      rd_idx_ff  <= rd_idx_in;
      chk_idx_ff <= chk_idx_in;
      found_ff   <= found_in;
      chosen_ff  <= chosen_in;
   end

   always_comb begin
      state_in      = state_ff;
      slot_count_in = slot_count_ff;
      chk_valid_in  = 1'b0;
      req_in        = req_ff;
      res_in        = res_ff;
      rd_idx_in     = rd_idx_ff;
      chk_idx_in    = chk_idx_ff;
      found_in      = found_ff;
      chosen_in     = chosen_ff;
      req_ready     = 1'b0;
      res_load      = 1'b0;
      wr            = '0;
      rd            = '0;

      case (state_ff)
         vsa_pkg::VSA_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in    = req_payload;
               rd_idx_in = '0;
               found_in  = 1'b0;
               chosen_in = '0;
               state_in  = vsa_pkg::VSA_SCAN;
            end
         end

         vsa_pkg::VSA_SCAN: begin
            // issue one read a cycle over the allocated slots
            if (rd_idx_ff < slot_count_ff) begin
               rd.en        = 1'b1;
               rd.addr      = rd_idx_ff[vsa_pkg::VOICE_W-1:0];
               rd_idx_in    = rd_idx_ff + 1'b1;
               chk_valid_in = 1'b1;
               chk_idx_in   = rd_idx_ff[vsa_pkg::VOICE_W-1:0];
            end
            // write back the slot read last cycle; different address from the read
            if (chk_valid_ff) begin
               wr.en                  = 1'b1;
               wr.addr                = chk_idx_ff;
               wr.data.reserved_flag  = rd_data.reserved_flag;
               wr.data.remaining_time = dec_time;
               if (!req_ff.continues_prev && !found_ff && !rd_data.reserved_flag
                   && dec_time == '0) begin
                  found_in  = 1'b1;
                  chosen_in = chk_idx_ff;
               end
            end
            if (!(rd_idx_ff < slot_count_ff) && !chk_valid_ff) begin
               state_in = vsa_pkg::VSA_WRITE;
            end
         end

         vsa_pkg::VSA_WRITE: begin
            res_in.new_voice = 1'b0;
            res_in.overflow  = 1'b0;
            if (req_ff.continues_prev) begin
               res_in.voice_number = req_ff.prev_voice;
            end else if (found_ff) begin
               res_in.voice_number = chosen_ff;
            end else if (slot_count_ff < vsa_pkg::COUNT_W'(vsa_pkg::MAX_VOICES)) begin
               res_in.voice_number = slot_count_ff[vsa_pkg::VOICE_W-1:0];
               res_in.new_voice    = 1'b1;
               slot_count_in       = slot_count_ff + 1'b1;
            end else begin
               res_in.voice_number = '0;
               res_in.overflow     = 1'b1;
            end
            res_in.voices_in_use   = slot_count_in;
            wr.en                  = !res_in.overflow;
            wr.addr                = res_in.voice_number;
            wr.data.reserved_flag  = req_ff.later_used;
            wr.data.remaining_time = req_ff.event_duration;
            state_in               = vsa_pkg::VSA_DONE;
         end

         vsa_pkg::VSA_DONE: begin
            if (out_free) begin
               res_load = 1'b1;
               state_in = vsa_pkg::VSA_IDLE;
            end
         end

         default: begin
            state_in = vsa_pkg::VSA_IDLE;
         end
      endcase
   end

   assign res_data = res_ff;

endmodule

`default_nettype wire

// ===== test/tb_voice_slot_allocator.sv =====
`timescale 1ns / 100ps

module tb_voice_slot_allocator;

   // Traffic shapes for the random part:
   //   churn - waits and durations of similar size, slots free up steadily
   //   pack  - short waits, long durations: the table fills and overflows
   //   wide  - full 24-bit waits and durations
   typedef enum logic [1:0] {
      MODE_CHURN,
      MODE_PACK,
      MODE_WIDE
   } traffic_mode_type;

   localparam int RANDOM_ITEMS = 1650;
   localparam int LONG_HOLD    = 300;   // one long receiver stall, in cycles
   localparam int HOLD_AFTER   = 400;   // results taken before that stall
   localparam int DRAIN_CYCLES = 40;    // wait after the last result

   // Clock, reset and block inputs, all known from time zero
   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   vsa_pkg::vsa_req_type req_payload = '0;
   logic                 rsp_ready   = 1'b0;
   logic                 req_ready;
   logic                 rsp_valid;
   vsa_pkg::vsa_rsp_type rsp_payload;

   // Items waiting to be offered, and results still owed by the block
   vsa_pkg::vsa_req_type pending_events[$];
   vsa_pkg::vsa_rsp_type expected_assignments[$];

   // Predicted voice table
   logic [vsa_pkg::TIME_W-1:0] slot_time [vsa_pkg::MAX_VOICES];
   logic                       slot_held [vsa_pkg::MAX_VOICES];
   int                         slots_used;

   bit  failed;
   bit  steady_flow;        // no random idling on either side while set
   int  send_gap;
   int  ready_stall_left;
   int  ready_stall;
   int  results_taken;
   bit  long_hold_done;
   vsa_pkg::vsa_rsp_type next_assignment;

   voice_slot_allocator dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      for (int v = 0; v < vsa_pkg::MAX_VOICES; v++) begin
         slot_time[v] = '0;
         slot_held[v] = 1'b0;
      end
      slots_used = 0;
   end

   // Idle length: mostly short, now and then long
   function automatic int pause_len();
      if (steady_flow)
         return 0;
      if ($urandom_range(0, 99) < 85)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Prediction for one accepted event. Every allocated slot first loses the
   // wait (floored at zero); then a continuation keeps its voice, anything
   // else takes the lowest run-out unreserved slot, else a fresh one, else
   // overflows. The chosen slot takes the new duration and later-used mark.
   task automatic assign_voice(input vsa_pkg::vsa_req_type ev);
      vsa_pkg::vsa_rsp_type res;
      bit                   found;
      res   = '0;
      found = 1'b0;
      for (int v = 0; v < slots_used; v++) begin
         if (slot_time[v] < ev.wait_time)
            slot_time[v] = '0;
         else
            slot_time[v] = slot_time[v] - ev.wait_time;
      end
      if (ev.continues_prev) begin
         // prev_voice is 4 bits, so with 16 slots it is always in range
         if (int'(ev.prev_voice) < vsa_pkg::MAX_VOICES) begin
            res.voice_number = ev.prev_voice;
            found = 1'b1;
         end
      end else begin
         for (int v = 0; v < slots_used; v++) begin
            if (!found && !slot_held[v] && slot_time[v] == '0) begin
               res.voice_number = vsa_pkg::VOICE_W'(v);
               found = 1'b1;
            end
         end
         if (!found && slots_used < vsa_pkg::MAX_VOICES) begin
            res.voice_number = vsa_pkg::VOICE_W'(slots_used);
            res.new_voice = 1'b1;
            slots_used++;
            found = 1'b1;
         end
      end
      if (found) begin
         slot_time[res.voice_number] = ev.event_duration;
         slot_held[res.voice_number] = ev.later_used;
      end else begin
         res.overflow = 1'b1;
      end
      res.voices_in_use = vsa_pkg::COUNT_W'(slots_used);
      expected_assignments.push_back(res);
   endtask

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                  $time, field, want, got);
         failed = 1'b1;
      end
   endtask

   function automatic vsa_pkg::vsa_req_type make_event(input int wait_ms, input bit cont,
                                                       input int prev, input bit later,
                                                       input int dur_ms);
      vsa_pkg::vsa_req_type ev;
      ev.wait_time      = vsa_pkg::TIME_W'(wait_ms);
      ev.continues_prev = cont;
      ev.prev_voice     = vsa_pkg::VOICE_W'(prev);
      ev.later_used     = later;
      ev.event_duration = vsa_pkg::TIME_W'(dur_ms);
      return ev;
   endfunction

   // Random event. Continuations mostly pick a slot that the predicted table
   // holds reserved, so reserve/continue chains get played out; the rest go
   // to any voice, allocated or not.
   function automatic vsa_pkg::vsa_req_type random_event(input traffic_mode_type mode);
      vsa_pkg::vsa_req_type ev;
      int                   held_list[$];
      ev = '0;
      case (mode)
         MODE_CHURN: begin
            ev.wait_time      = vsa_pkg::TIME_W'($urandom_range(0, 2000));
            ev.event_duration = vsa_pkg::TIME_W'($urandom_range(0, 2000));
         end
         MODE_PACK: begin
            ev.wait_time      = vsa_pkg::TIME_W'($urandom_range(0, 100));
            ev.event_duration = vsa_pkg::TIME_W'($urandom_range(1000, 100000));
         end
         default: begin
            ev.wait_time      = vsa_pkg::TIME_W'($urandom());
            ev.event_duration = vsa_pkg::TIME_W'($urandom());
         end
      endcase
      ev.later_used = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) < 3) begin
         ev.continues_prev = 1'b1;
         for (int v = 0; v < vsa_pkg::MAX_VOICES; v++)
            if (slot_held[v])
               held_list.push_back(v);
         if (held_list.size() > 0 && $urandom_range(0, 3) != 0)
            ev.prev_voice = vsa_pkg::VOICE_W'(
               held_list[$urandom_range(0, held_list.size() - 1)]);
         else
            ev.prev_voice = vsa_pkg::VOICE_W'($urandom_range(0, vsa_pkg::MAX_VOICES - 1));
      end else begin
         ev.prev_voice = vsa_pkg::VOICE_W'($urandom_range(0, vsa_pkg::MAX_VOICES - 1));
      end
      return ev;
   endfunction

   // Keep only a short lookahead so continuations see a near-current table
   task automatic queue_event(input vsa_pkg::vsa_req_type ev);
      wait (pending_events.size() < 2);
      pending_events.push_back(ev);
   endtask

   // Driver: offers queued items, holds each until taken, and runs the
   // prediction at the edge that accepts it.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && req_ready)
            assign_voice(req_payload);
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap  <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_events.size() > 0) begin
               req_payload <= pending_events.pop_front();
               req_valid   <= 1'b1;
               send_gap    <= ($urandom_range(0, 1) == 0) ? pause_len() : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off once enough results have
   // been taken, long enough for the block to fill and refuse new items.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready        <= 1'b0;
         ready_stall_left  = 0;
         results_taken     = 0;
      end else begin
         if (rsp_valid && rsp_ready)
            results_taken++;
         if (ready_stall_left != 0) begin
            ready_stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (!long_hold_done && results_taken >= HOLD_AFTER) begin
               long_hold_done = 1'b1;
               ready_stall    = LONG_HOLD;
            end else begin
               ready_stall = ($urandom_range(0, 3) == 0) ? pause_len() : 0;
            end
            if (ready_stall > 0) begin
               rsp_ready       <= 1'b0;
               ready_stall_left = ready_stall - 1;
            end else begin
               rsp_ready <= 1'b1;
            end
         end
      end
   end

   // Monitor: each taken result against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_assignments.size() == 0) begin
            $display("%0t ns: result with none expected, actual voice %0d",
                     $time, rsp_payload.voice_number);
            failed = 1'b1;
         end else begin
            next_assignment = expected_assignments.pop_front();
            check_field("voice_number", next_assignment.voice_number,
                        rsp_payload.voice_number);
            check_field("new_voice", next_assignment.new_voice, rsp_payload.new_voice);
            check_field("overflow", next_assignment.overflow, rsp_payload.overflow);
            check_field("voices_in_use", next_assignment.voices_in_use,
                        rsp_payload.voices_in_use);
         end
      end
   end

   initial begin
      traffic_mode_type mode;
      int               phase_len;
      int               random_sent;
      int               phase_no;
      random_sent = 0;
      phase_no    = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed opening
      queue_event(make_event(0, 0, 0, 0, 0));               // fresh slot 0
      queue_event(make_event(24'hFFFFFF, 0, 0, 1, 24'hFFFFFF)); // zero duration freed 0
      queue_event(make_event(0, 0, 0, 0, 0));               // 0 reserved: fresh slot 1
      queue_event(make_event(0, 1, 15, 1, 5));              // continue unallocated slot
      queue_event(make_event(0, 1, 0, 0, 0));               // release reserved slot 0
      queue_event(make_event(1, 0, 0, 0, 24'h800000));      // reuse slot 0
      queue_event(make_event(0, 0, 0, 1, 1));               // slot 1 ran out: reuse
      queue_event(make_event(24'h7FFFFF, 0, 0, 0, 24'h123456)); // 0 busy by one ms
      queue_event(make_event(1, 0, 0, 0, 0));               // now slot 0 is free
      queue_event(make_event(0, 1, 1, 0, 24'hFFFFFF));      // continue and release 1
      queue_event(make_event(24'hFFFFFF, 1, 10, 0, 24'hAAAAAA));
      queue_event(make_event(24'h555555, 0, 5, 1, 24'h555555));

      // Random phases; the first one churns so slots grow gradually
      while (random_sent < RANDOM_ITEMS) begin
         mode        = (phase_no == 0) ? MODE_CHURN
                                       : traffic_mode_type'($urandom_range(0, 2));
         steady_flow = ($urandom_range(0, 3) == 0);
         phase_len   = $urandom_range(20, 80);
         for (int i = 0; i < phase_len && random_sent < RANDOM_ITEMS; i++) begin
            queue_event(random_event(mode));
            random_sent++;
         end
         // Every so often the sender stops until the block has answered all;
         // sampled at the falling edge, once the driver's updates have settled
         if (phase_no % 4 == 3) begin
            while (pending_events.size() != 0 || req_valid
                   || expected_assignments.size() != 0)
               @(negedge clock);
         end
         phase_no++;
      end
      steady_flow = 1'b0;

      while (pending_events.size() != 0 || req_valid
             || expected_assignments.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (!failed && expected_assignments.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // Watchdog, far beyond the slowest correct run
   initial begin
      #10_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
